>>> hw/rtl/huffman_tree_load_and_decode_core_defines.svh
// assertion macros for the huffman tree load and decode core
// used by the port checker; no other dependencies
`ifndef HUFFMAN_TREE_LOAD_AND_DECODE_CORE_DEFINES_SVH
`define HUFFMAN_TREE_LOAD_AND_DECODE_CORE_DEFINES_SVH

// same-cycle implication
`define HTLD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HTLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/htld_pkg.sv
// shared constants, codes and types for the huffman tree load and decode core
// no dependencies
`default_nettype none

package htld_pkg;

   localparam int NODE_DEPTH = 512;
   localparam int MAX_LEAVES = 256;

   localparam int NODE_IW  = $clog2(NODE_DEPTH);
   localparam int ENTRY_W  = 2 * NODE_IW + 1;
   localparam int LEAF_BIT = ENTRY_W - 1;
   localparam int STK_AW   = $clog2(MAX_LEAVES);
   localparam int LVL_W    = STK_AW + 1;
   localparam int NCNT_W   = NODE_IW + 1;
   localparam int SUM_W    = ((NCNT_W > LVL_W) ? NCNT_W : LVL_W) + 1;

   localparam int BYTE_W     = 8;
   localparam int BIT_CW     = $clog2(BYTE_W);
   localparam int COUNT_W    = 32;
   localparam int STATUS_W   = 3;
   localparam int OP_W       = 2;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_PAD_W  = RSP_DATA_W - STATUS_W - BYTE_W;

   localparam logic [OP_W-1:0] OP_TREE    = 2'd0;
   localparam logic [OP_W-1:0] OP_DATA    = 2'd1;
   localparam logic [OP_W-1:0] OP_RESTART = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_ACCEPTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_TREE_DONE = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_MALFORMED = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_READY = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_SYMBOL = 1'b1;

   localparam logic [BYTE_W-1:0] CH_ONE  = 8'h31;
   localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NL   = 8'h0A;

   typedef struct packed {
      logic                kind;
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   symbol;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } unit_res_type;

   typedef struct packed {
      logic               en;
      logic [NODE_IW-1:0] addr;
   } node_rd_type;

   typedef struct packed {
      logic               en;
      logic [NODE_IW-1:0] addr;
      logic [ENTRY_W-1:0] data;
   } node_wr_type;

endpackage

`default_nettype wire

>>> hw/rtl/htld_tree.sv
// tree builder: post-order parser with build stack memory and top-of-stack register
// depends on htld_pkg; node table lives in the top level
`default_nettype none

module htld_tree (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [htld_pkg::OP_W-1:0]          op,
   input  logic [htld_pkg::BYTE_W-1:0]        byte_in,
   input  logic [htld_pkg::ENTRY_W-1:0]       node_rd_data,
   input  logic                               res_take,
   output logic                               busy,
   output logic                               ready,
   output htld_pkg::node_rd_type              node_rd,
   output htld_pkg::node_wr_type              node_wr,
   output logic                               root_load,
   output logic [htld_pkg::ENTRY_W-2:0]       root_entry,
   output htld_pkg::unit_res_type             res
);

   localparam logic [1:0] TS_IDLE = 2'd0;
   localparam logic [1:0] TS_POP  = 2'd1;
   localparam logic [1:0] TS_CHK  = 2'd2;
   localparam logic [1:0] TS_RES  = 2'd3;

   localparam logic [2:0] PH_MARK  = 3'd0;
   localparam logic [2:0] PH_LEAF  = 3'd1;
   localparam logic [2:0] PH_READY = 3'd2;
   localparam logic [2:0] PH_BAD   = 3'd3;
   localparam logic [2:0] PH_FULL  = 3'd4;

   logic [1:0]                          tst_ff, tst_in;
   logic [2:0]                          phase_ff, phase_in;
   logic [htld_pkg::LVL_W-1:0]          level_ff, level_in;
   logic [htld_pkg::NCNT_W-1:0]         nodes_ff, nodes_in;
   logic [htld_pkg::NODE_IW-1:0]        tos_ff, tos_in;
   logic [htld_pkg::STATUS_W-1:0]       stat_ff, stat_in;

   logic [htld_pkg::NODE_IW-1:0]        stk_mem [htld_pkg::MAX_LEAVES];
   logic [htld_pkg::NODE_IW-1:0]        stk_q_ff;
   logic                                stk_we;
   logic [htld_pkg::STK_AW-1:0]         stk_waddr;
   logic [htld_pkg::NODE_IW-1:0]        stk_wdata;
   logic                                stk_re;
   logic [htld_pkg::STK_AW-1:0]         stk_raddr;

   logic [htld_pkg::LVL_W-1:0]          level_m1;
   logic [htld_pkg::LVL_W-1:0]          level_m2;
   logic [htld_pkg::SUM_W-1:0]          fill_sum;
   logic                                leaf_room;
   logic [htld_pkg::NODE_IW-1:0]        new_idx;

   assign level_m1  = level_ff - htld_pkg::LVL_W'(1);
   assign level_m2  = level_ff - htld_pkg::LVL_W'(2);
   // nodes + stack depth is twice the number of leaves
   assign fill_sum  = htld_pkg::SUM_W'(nodes_ff) + htld_pkg::SUM_W'(level_ff);
   assign leaf_room = (fill_sum < htld_pkg::SUM_W'(2 * htld_pkg::MAX_LEAVES)) &&
                      (nodes_ff < htld_pkg::NCNT_W'(htld_pkg::NODE_DEPTH));
   assign new_idx   = nodes_ff[htld_pkg::NODE_IW-1:0];

   always_comb begin
      tst_in     = tst_ff;
      phase_in   = phase_ff;
      level_in   = level_ff;
      nodes_in   = nodes_ff;
      tos_in     = tos_ff;
      stat_in    = stat_ff;
      node_rd    = '0;
      node_wr    = '0;
      stk_we     = 1'b0;
      stk_waddr  = level_m1[htld_pkg::STK_AW-1:0];
      stk_wdata  = tos_ff;
      stk_re     = 1'b0;
      stk_raddr  = level_m2[htld_pkg::STK_AW-1:0];
      root_load  = 1'b0;

      unique case (tst_ff)
         TS_IDLE: begin
            if (start) begin
               tst_in  = TS_RES;
               stat_in = htld_pkg::STAT_ACCEPTED;
               unique case (op)
                  htld_pkg::OP_RESTART: begin
                     phase_in = PH_MARK;
                     level_in = '0;
                     nodes_in = '0;
                  end
                  htld_pkg::OP_DATA: begin
                     stat_in = htld_pkg::STAT_NOT_READY;
                  end
                  htld_pkg::OP_NOP: begin
                     stat_in = htld_pkg::STAT_ACCEPTED;
                  end
                  htld_pkg::OP_TREE: begin
                     unique case (phase_ff)
                        PH_READY, PH_BAD: begin
                           stat_in = htld_pkg::STAT_MALFORMED;
                        end
                        PH_FULL: begin
                           stat_in = htld_pkg::STAT_FULL;
                        end
                        PH_LEAF: begin
                           node_wr.en   = 1'b1;
                           node_wr.addr = new_idx;
                           node_wr.data = {1'b1,
                                           {(htld_pkg::ENTRY_W - 1 - htld_pkg::BYTE_W){1'b0}},
                                           byte_in};
                           // push: old top spills into the stack memory
                           stk_we   = (level_ff != '0);
                           tos_in   = new_idx;
                           level_in = level_ff + htld_pkg::LVL_W'(1);
                           nodes_in = nodes_ff + htld_pkg::NCNT_W'(1);
                           phase_in = PH_MARK;
                        end
                        PH_MARK: begin
                           priority if (byte_in == htld_pkg::CH_ONE) begin
                              if (leaf_room) begin
                                 phase_in = PH_LEAF;
                              end else begin
                                 phase_in = PH_FULL;
                                 stat_in  = htld_pkg::STAT_FULL;
                              end
                           end else if (byte_in == htld_pkg::CH_ZERO) begin
                              if (level_ff < htld_pkg::LVL_W'(2)) begin
                                 phase_in = PH_BAD;
                                 stat_in  = htld_pkg::STAT_MALFORMED;
                              end else if (nodes_ff >=
                                           htld_pkg::NCNT_W'(htld_pkg::NODE_DEPTH)) begin
                                 phase_in = PH_FULL;
                                 stat_in  = htld_pkg::STAT_FULL;
                              end else begin
                                 // right child is the top register, fetch the left one
                                 stk_re = 1'b1;
                                 tst_in = TS_POP;
                              end
                           end else if (byte_in == htld_pkg::CH_NL) begin
                              if (level_ff != htld_pkg::LVL_W'(1)) begin
                                 phase_in = PH_BAD;
                                 stat_in  = htld_pkg::STAT_MALFORMED;
                              end else begin
                                 node_rd.en   = 1'b1;
                                 node_rd.addr = tos_ff;
                                 tst_in       = TS_CHK;
                              end
                           end else begin
                              phase_in = PH_BAD;
                              stat_in  = htld_pkg::STAT_MALFORMED;
                           end
                        end
                        default: begin
                           phase_in = PH_BAD;
                           stat_in  = htld_pkg::STAT_MALFORMED;
                        end
                     endcase
                  end
                  default: begin
                     stat_in = htld_pkg::STAT_ACCEPTED;
                  end
               endcase
            end
         end
         TS_POP: begin
            node_wr.en   = 1'b1;
            node_wr.addr = new_idx;
            node_wr.data = {1'b0, stk_q_ff, tos_ff};
            // two popped, one pushed: the new node simply replaces the top
            tos_in   = new_idx;
            level_in = level_m1;
            nodes_in = nodes_ff + htld_pkg::NCNT_W'(1);
            stat_in  = htld_pkg::STAT_ACCEPTED;
            tst_in   = TS_RES;
         end
         TS_CHK: begin
            if (node_rd_data[htld_pkg::LEAF_BIT]) begin
               phase_in = PH_BAD;
               stat_in  = htld_pkg::STAT_MALFORMED;
            end else begin
               phase_in  = PH_READY;
               stat_in   = htld_pkg::STAT_TREE_DONE;
               level_in  = '0;
               root_load = 1'b1;
            end
            tst_in = TS_RES;
         end
         TS_RES: begin
            if (res_take) begin
               tst_in = TS_IDLE;
            end
         end
         default: begin
            tst_in = TS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tst_ff   <= TS_IDLE;
         phase_ff <= PH_MARK;
         level_ff <= '0;
         nodes_ff <= '0;
      end else begin
         tst_ff   <= tst_in;
         phase_ff <= phase_in;
         level_ff <= level_in;
         nodes_ff <= nodes_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff  <= tos_in;
      stat_ff <= stat_in;
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stk_q_ff <= stk_mem[stk_raddr];
      end
   end

   assign root_entry     = node_rd_data[htld_pkg::ENTRY_W-2:0];
   assign busy           = (tst_ff != TS_IDLE);
   assign ready          = (phase_ff == PH_READY);
   assign res.valid      = (tst_ff == TS_RES);
   assign res.rsp.kind   = htld_pkg::KIND_STATUS;
   assign res.rsp.status = stat_ff;
   assign res.rsp.symbol = '0;
   assign res.rsp.last   = 1'b1;

endmodule

`default_nettype wire

>>> hw/rtl/htld_walk.sv
// code walker: shifts a data byte out msb first, one node table read per bit
// depends on htld_pkg; node table read port is granted by the top level
`default_nettype none

module htld_walk (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [htld_pkg::BYTE_W-1:0]        byte_in,
   input  logic                               restart,
   input  logic [htld_pkg::COUNT_W-1:0]       symbol_count,
   input  logic                               root_load,
   input  logic [htld_pkg::ENTRY_W-2:0]       root_entry,
   input  logic [htld_pkg::ENTRY_W-1:0]       node_rd_data,
   input  logic                               res_take,
   output logic                               busy,
   output htld_pkg::node_rd_type              node_rd,
   output htld_pkg::unit_res_type             res
);

   localparam logic [1:0] WS_IDLE  = 2'd0;
   localparam logic [1:0] WS_RUN   = 2'd1;
   localparam logic [1:0] WS_FLUSH = 2'd2;

   localparam int IW = htld_pkg::NODE_IW;

   logic [1:0]                          wst_ff, wst_in;
   logic [htld_pkg::BIT_CW-1:0]         cnt_ff, cnt_in;
   logic [htld_pkg::BYTE_W-1:0]         shreg_ff, shreg_in;
   logic [htld_pkg::ENTRY_W-2:0]        cur_ff, cur_in;
   logic [htld_pkg::ENTRY_W-2:0]        root_ff, root_in;
   logic [htld_pkg::COUNT_W-1:0]        left_ff, left_in;
   logic                                pend_vld_ff, pend_vld_in;
   logic [htld_pkg::BYTE_W-1:0]         pend_sym_ff, pend_sym_in;

   logic                                leaf;
   logic [htld_pkg::ENTRY_W-2:0]        next_e;
   logic                                emit_old;
   logic                                stall;
   logic                                done;

   assign leaf     = node_rd_data[htld_pkg::LEAF_BIT];
   assign next_e   = leaf ? root_ff : node_rd_data[htld_pkg::ENTRY_W-2:0];
   // a new leaf pushes the held symbol out, which needs the output slot
   assign emit_old = (wst_ff == WS_RUN) && leaf && pend_vld_ff;
   assign stall    = emit_old && !res_take;
   assign done     = (cnt_ff == htld_pkg::BIT_CW'(htld_pkg::BYTE_W - 1)) ||
                     (leaf && (left_ff == htld_pkg::COUNT_W'(1)));

   always_comb begin
      wst_in      = wst_ff;
      cnt_in      = cnt_ff;
      shreg_in    = shreg_ff;
      cur_in      = cur_ff;
      root_in     = root_ff;
      left_in     = left_ff;
      pend_vld_in = pend_vld_ff;
      pend_sym_in = pend_sym_ff;
      node_rd     = '0;

      if (restart) begin
         left_in = symbol_count;
      end
      if (root_load) begin
         cur_in  = root_entry;
         root_in = root_entry;
      end

      unique case (wst_ff)
         WS_IDLE: begin
            if (start) begin
               pend_vld_in = 1'b0;
               if (left_ff == '0) begin
                  wst_in = WS_FLUSH;
               end else begin
                  node_rd.en   = 1'b1;
                  node_rd.addr = byte_in[htld_pkg::BYTE_W-1] ? cur_ff[IW-1:0]
                                                             : cur_ff[2*IW-1:IW];
                  shreg_in     = byte_in << 1;
                  cnt_in       = '0;
                  wst_in       = WS_RUN;
               end
            end
         end
         WS_RUN: begin
            if (!stall) begin
               cur_in = next_e;
               if (leaf) begin
                  pend_vld_in = 1'b1;
                  pend_sym_in = node_rd_data[htld_pkg::BYTE_W-1:0];
                  left_in     = left_ff - htld_pkg::COUNT_W'(1);
               end
               if (done) begin
                  wst_in = WS_FLUSH;
               end else begin
                  node_rd.en   = 1'b1;
                  node_rd.addr = shreg_ff[htld_pkg::BYTE_W-1] ? next_e[IW-1:0]
                                                              : next_e[2*IW-1:IW];
                  shreg_in     = shreg_ff << 1;
                  cnt_in       = cnt_ff + htld_pkg::BIT_CW'(1);
               end
            end
         end
         WS_FLUSH: begin
            if (res_take) begin
               pend_vld_in = 1'b0;
               wst_in      = WS_IDLE;
            end
         end
         default: begin
            wst_in = WS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wst_ff      <= WS_IDLE;
         left_ff     <= '0;
         pend_vld_ff <= 1'b0;
      end else begin
         wst_ff      <= wst_in;
         left_ff     <= left_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      shreg_ff    <= shreg_in;
      cur_ff      <= cur_in;
      root_ff     <= root_in;
      pend_sym_ff <= pend_sym_in;
   end

   always_comb begin
      res.valid      = emit_old || (wst_ff == WS_FLUSH);
      res.rsp.status = htld_pkg::STAT_ACCEPTED;
      if ((wst_ff == WS_FLUSH) && !pend_vld_ff) begin
         res.rsp.kind   = htld_pkg::KIND_STATUS;
         res.rsp.symbol = '0;
      end else begin
         res.rsp.kind   = htld_pkg::KIND_SYMBOL;
         res.rsp.symbol = pend_sym_ff;
      end
      res.rsp.last = (wst_ff == WS_FLUSH);
   end

   assign busy = (wst_ff != WS_IDLE);

endmodule

`default_nettype wire

>>> hw/rtl/huffman_tree_load_and_decode_core.sv
// top level: dispatch, node table memory, output register, symbol count register
// depends on htld_pkg, htld_tree, htld_walk
//
//   group  dir  payload                                   handshake
//   req_   in   tdata[7:0] byte_in, tuser[1:0] operation   req_tvalid / req_tready
//   rsp_   out  tdata status, symbol; tuser kind; tlast    rsp_tvalid / rsp_tready
//   csr_   in   data[31:0] symbol_count                    csr_valid / csr_ready
//
// one item at a time; the input waits until the item's last result sits in the output register
// a data byte walks its eight code bits msb first with one node table read each, then hands
// over the final beat; it ends early once the count runs out
// tree bytes and status-only items go straight to their result, a join first through the
// pop state and a closing newline through the check state; a symbol beat that finds the
// output register full stalls the bit walk, a final beat that finds it full holds off the
// next item; reset is synchronous; node table and build stack keep their contents, a restart
// item clears the tree state
`default_nettype none

module huffman_tree_load_and_decode_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [htld_pkg::BYTE_W-1:0]          req_tdata,   // [7:0] byte_in
   input  logic [htld_pkg::OP_W-1:0]            req_tuser,   // [1:0] operation
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [htld_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // [2:0] status, [10:3] symbol
   output logic                                 rsp_tuser,   // [0] kind
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [htld_pkg::COUNT_W-1:0]         csr_data
);

   logic [htld_pkg::COUNT_W-1:0]        count_ff;

   logic                                accept;
   logic                                to_walk;
   logic                                tree_busy;
   logic                                tree_ready;
   logic                                walk_busy;
   logic                                root_load;
   logic [htld_pkg::ENTRY_W-2:0]        root_entry;
   htld_pkg::node_rd_type               tree_rd;
   htld_pkg::node_rd_type               walk_rd;
   htld_pkg::node_rd_type               rd_sel;
   htld_pkg::node_wr_type               tree_wr;
   htld_pkg::unit_res_type              tree_res;
   htld_pkg::unit_res_type              walk_res;
   htld_pkg::unit_res_type              res_sel;

   logic [htld_pkg::ENTRY_W-1:0]        node_mem [htld_pkg::NODE_DEPTH];
   logic [htld_pkg::ENTRY_W-1:0]        node_q_ff;

   logic                                out_free;
   logic                                rsp_vld_ff, rsp_vld_in;
   htld_pkg::rsp_type                   rsp_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid) begin
         count_ff <= csr_data;
      end
   end

   assign req_tready = !tree_busy && !walk_busy;
   assign accept     = req_tvalid && req_tready;
   assign to_walk    = (req_tuser == htld_pkg::OP_DATA) && tree_ready;

   htld_tree u_tree (
      .clock        (clock),
      .reset        (reset),
      .start        (accept && !to_walk),
      .op           (req_tuser),
      .byte_in      (req_tdata),
      .node_rd_data (node_q_ff),
      .res_take     (out_free),
      .busy         (tree_busy),
      .ready        (tree_ready),
      .node_rd      (tree_rd),
      .node_wr      (tree_wr),
      .root_load    (root_load),
      .root_entry   (root_entry),
      .res          (tree_res)
   );

   htld_walk u_walk (
      .clock        (clock),
      .reset        (reset),
      .start        (accept && to_walk),
      .byte_in      (req_tdata),
      .restart      (accept && (req_tuser == htld_pkg::OP_RESTART)),
      .symbol_count (count_ff),
      .root_load    (root_load),
      .root_entry   (root_entry),
      .node_rd_data (node_q_ff),
      .res_take     (out_free),
      .busy         (walk_busy),
      .node_rd      (walk_rd),
      .res          (walk_res)
   );

   // only one unit is active at a time
   assign rd_sel = tree_rd.en ? tree_rd : walk_rd;

   always_ff @(posedge clock) begin
      if (tree_wr.en) begin
         node_mem[tree_wr.addr] <= tree_wr.data;
      end
      if (rd_sel.en) begin
         node_q_ff <= node_mem[rd_sel.addr];
      end
   end

   assign out_free = !rsp_vld_ff || rsp_tready;
   assign res_sel  = tree_res.valid ? tree_res : walk_res;

   always_comb begin
      if (out_free && res_sel.valid) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && res_sel.valid) begin
         rsp_ff <= res_sel.rsp;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{htld_pkg::RSP_PAD_W{1'b0}}, rsp_ff.symbol, rsp_ff.status};
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;

endmodule

`default_nettype wire

>>> hw/rtl/htld_checker.sv
// port checker for the huffman tree load and decode core, bound to the top level
// depends on htld_pkg and huffman_tree_load_and_decode_core_defines.svh
`include "huffman_tree_load_and_decode_core_defines.svh"
`default_nettype none

module htld_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [htld_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              rsp_tuser,
   input  logic                              rsp_tlast
);

   `HTLD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "result beat changed while stalled")

   // a status beat is always the only and final result of its item
   `HTLD_ASSERT_NOW(a_status_beat, clock, reset, rsp_tvalid && (rsp_tuser == htld_pkg::KIND_STATUS), rsp_tlast && (rsp_tdata[10:3] == '0), "status beat without last or with a symbol")

   `HTLD_ASSERT_NOW(a_symbol_beat, clock, reset, rsp_tvalid && (rsp_tuser == htld_pkg::KIND_SYMBOL), rsp_tdata[2:0] == htld_pkg::STAT_ACCEPTED, "symbol beat with nonzero status")

   `HTLD_ASSERT_NOW(a_status_code, clock, reset, rsp_tvalid, (rsp_tdata[2:0] <= htld_pkg::STAT_FULL) && (rsp_tdata[15:11] == '0), "undefined status code or padding set")

endmodule

bind huffman_tree_load_and_decode_core htld_checker u_htld_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
